// ----- design/i2cm_pkg.sv -----
// shared types and constants for the i2c master byte engine
`timescale 1ns / 1ps

package i2cm_pkg;

  // command codes on the func field
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  // segment lengths, stored as ticks left after the first one
  localparam logic [1:0] TICKS_SETUP = 2'd3;
  localparam logic [1:0] TICKS_HALF  = 2'd1;
  localparam logic [1:0] TICKS_ONE   = 2'd0;

  localparam logic [9:0] POLL_LIMIT_RESET = 10'd250;
  localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_READ,
    CMD_STOP
  } cmd_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_WRITE,
    OP_READ,
    OP_STOP,
    OP_STOP_ERR
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_TX_LOW,
    PH_TX_HIGH,
    PH_TX_TAIL,
    PH_ACK_A,
    PH_ACK_B,
    PH_POLL,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_ANS_LOW,
    PH_ANS_HIGH,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C
  } phase_t;

  // one classified tick waiting for the sequencer
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       sda_in;
  } item_t;

  // what the sequencer reports for one tick
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       nack;
    logic [7:0] read_data;
  } res_t;

endpackage

// ----- design/i2c_master_byte_engine_top.sv -----
// top level of the i2c master byte engine: queue, sequencer, result register
`timescale 1ns / 1ps

// Each input beat is one bus timebase tick (nominally 1 us) carrying an
// optional byte command and the sampled SDA level; each beat yields exactly
// one result beat with the SCL/SDA drives after that tick, busy, done, the
// nack error flag and the received byte. The block takes one beat per clock
// cycle while out_stall lets the result slot drain; each beat is held in the
// input queue, then stepped through the segment sequencer into the output
// register. The input queue is QUEUE_DEPTH beats deep, so stalls on the result
// side reach in_stall only once the queue has filled. Commands arriving while
// busy are ignored. The user must write the acknowledge poll limit through the
// cfg port only while no command is running; the block does not enforce this (reset 250).

module i2c_master_byte_engine_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [7:0] in_dev_addr,
  input  logic       in_is_read,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_nack_error,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data
);
  import i2cm_pkg::*;

  logic       q_valid;
  item_t      q_item;
  logic       step;
  res_t       res;
  res_t       res_r;
  logic       out_valid_r, out_valid_nxt;
  logic [9:0] poll_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poll_limit_r <= cfg_data;
    end
  end

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_dev_addr  (in_dev_addr),
    .in_is_read   (in_is_read),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_sda_in    (in_sda_in),
    .q_pop        (step),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  // sequencer advances whenever a beat is queued and the result slot frees up
  assign step = q_valid && (!out_valid_r || !out_stall);

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (q_item),
    .poll_limit (poll_limit_r),
    .res        (res)
  );

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = res_r.scl;
  assign out_sda_level  = res_r.sda;
  assign out_busy_res   = res_r.busy;
  assign out_done_res   = res_r.done;
  assign out_nack_error = res_r.nack;
  assign out_read_data  = res_r.read_data;

`ifndef ASSERT_OFF
  // a finished command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("done reported while still busy");

  // an error only comes at the end of the stop, with both lines released
  a_nack_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_nack_error) |-> (out_done_res && out_scl_level && out_sda_level))
    else $error("nack error without completed stop");

  // received data is shown only on the finishing beat
  a_read_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_data != 8'd0)) |-> out_done_res)
    else $error("read data outside done beat");

  // the result slot is reloaded only when it is empty or being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result beat lost");
`endif

endmodule

// ----- design/i2cm_front.sv -----
// input side: decodes each tick beat and holds it in a short queue
`timescale 1ns / 1ps

module i2cm_front #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_func,
  input  logic [7:0]       in_dev_addr,
  input  logic             in_is_read,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             in_sda_in,
  input  logic             q_pop,
  output logic             q_valid,
  output i2cm_pkg::item_t  q_item
);
  import i2cm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  item_t            new_item;

  // classify the command and build the byte the bus will shift out
  always_comb begin
    new_item.last_byte = in_last_byte;
    new_item.sda_in    = in_sda_in;
    new_item.tx_byte   = '0;
    case (in_func)
      FUNC_START: begin
        new_item.cmd     = CMD_START;
        new_item.tx_byte = in_dev_addr + {7'd0, in_is_read};
      end
      FUNC_WRITE: begin
        new_item.cmd     = CMD_WRITE;
        new_item.tx_byte = in_data_byte;
      end
      FUNC_READ:  new_item.cmd = CMD_READ;
      FUNC_STOP:  new_item.cmd = CMD_STOP;
      default:    new_item.cmd = CMD_NONE;
    endcase
  end

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- design/i2cm_back.sv -----
// bus sequencer: walks the scl/sda segments one tick beat at a time
`timescale 1ns / 1ps

module i2cm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cm_pkg::item_t  item,
  input  logic [9:0]       poll_limit,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  typedef struct packed {
    logic [1:0] ticks;
    logic       scl;
    logic       sda;
  } drive_t;

  function automatic drive_t drive_for(phase_t ph, logic txbit, logic ackm);
    drive_t d;
    d = '{ticks: TICKS_ONE, scl: 1'b1, sda: 1'b1};
    case (ph)
      PH_START_A:  d = '{ticks: TICKS_SETUP, scl: 1'b1, sda: 1'b1};
      PH_START_B:  d = '{ticks: TICKS_SETUP, scl: 1'b1, sda: 1'b0};
      PH_TX_LOW:   d = '{ticks: TICKS_HALF,  scl: 1'b0, sda: txbit};
      PH_TX_HIGH:  d = '{ticks: TICKS_HALF,  scl: 1'b1, sda: txbit};
      PH_TX_TAIL:  d = '{ticks: TICKS_HALF,  scl: 1'b0, sda: txbit};
      PH_ACK_A:    d = '{ticks: TICKS_ONE,   scl: 1'b0, sda: 1'b1};
      PH_RX_LOW:   d = '{ticks: TICKS_HALF,  scl: 1'b0, sda: 1'b1};
      PH_ANS_LOW:  d = '{ticks: TICKS_HALF,  scl: 1'b0, sda: ackm};
      PH_ANS_HIGH: d = '{ticks: TICKS_HALF,  scl: 1'b1, sda: ackm};
      PH_STOP_A:   d = '{ticks: TICKS_SETUP, scl: 1'b0, sda: 1'b0};
      PH_STOP_B:   d = '{ticks: TICKS_SETUP, scl: 1'b1, sda: 1'b0};
      PH_STOP_C:   d = '{ticks: TICKS_SETUP, scl: 1'b1, sda: 1'b1};
      default:     d = '{ticks: TICKS_ONE,   scl: 1'b1, sda: 1'b1};
    endcase
    return d;
  endfunction

  op_t        op_r, op_nxt;
  phase_t     ph_r, ph_nxt;
  logic [1:0] tick_r, tick_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [9:0] poll_r, poll_nxt;
  logic       ackm_r, ackm_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  logic       ent;
  phase_t     ent_ph;
  logic       poll_chk;
  logic [9:0] poll_base;
  logic       fin;
  logic       fin_scl_low;
  drive_t     drv;
  logic       done;
  logic       err;
  logic       rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_IDLE;
      ph_r   <= PH_IDLE;
      tick_r <= '0;
      bc_r   <= '0;
      sh_r   <= '0;
      poll_r <= '0;
      ackm_r <= 1'b0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
    end else if (step) begin
      op_r   <= op_nxt;
      ph_r   <= ph_nxt;
      tick_r <= tick_nxt;
      bc_r   <= bc_nxt;
      sh_r   <= sh_nxt;
      poll_r <= poll_nxt;
      ackm_r <= ackm_nxt;
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
    end
  end

  always_comb begin
    op_nxt      = op_r;
    ph_nxt      = ph_r;
    tick_nxt    = tick_r;
    bc_nxt      = bc_r;
    sh_nxt      = sh_r;
    poll_nxt    = poll_r;
    ackm_nxt    = ackm_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ent         = 1'b0;
    ent_ph      = PH_IDLE;
    poll_chk    = 1'b0;
    poll_base   = poll_r;
    fin         = 1'b0;
    fin_scl_low = 1'b0;
    drv         = '{ticks: TICKS_ONE, scl: 1'b1, sda: 1'b1};
    done        = 1'b0;
    err         = 1'b0;
    rd          = 1'b0;

    if (op_r == OP_IDLE) begin
      case (item.cmd)
        CMD_START: begin
          op_nxt = OP_START;
          sh_nxt = item.tx_byte;
          bc_nxt = '0;
          ent    = 1'b1;
          ent_ph = PH_START_A;
        end
        CMD_WRITE: begin
          op_nxt = OP_WRITE;
          sh_nxt = item.tx_byte;
          bc_nxt = '0;
          ent    = 1'b1;
          ent_ph = PH_TX_LOW;
        end
        CMD_READ: begin
          op_nxt   = OP_READ;
          sh_nxt   = '0;
          bc_nxt   = '0;
          ackm_nxt = item.last_byte;
          ent      = 1'b1;
          ent_ph   = PH_RX_LOW;
        end
        CMD_STOP: begin
          op_nxt = OP_STOP;
          ent    = 1'b1;
          ent_ph = PH_STOP_A;
        end
        default: ;
      endcase
    end else if (ph_r == PH_POLL) begin
      poll_chk = 1'b1;
    end else if (tick_r != '0) begin
      tick_nxt = tick_r - 1'b1;
    end else begin
      case (ph_r)
        PH_START_A: begin
          ent    = 1'b1;
          ent_ph = PH_START_B;
        end
        PH_START_B: begin
          bc_nxt = '0;
          ent    = 1'b1;
          ent_ph = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          ent    = 1'b1;
          ent_ph = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          ent    = 1'b1;
          ent_ph = PH_TX_TAIL;
        end
        PH_TX_TAIL: begin
          sh_nxt = {sh_r[6:0], 1'b0};
          bc_nxt = bc_r + 1'b1;
          ent    = 1'b1;
          ent_ph = (bc_nxt >= BITS_PER_BYTE) ? PH_ACK_A : PH_TX_LOW;
        end
        PH_ACK_A: begin
          ent    = 1'b1;
          ent_ph = PH_ACK_B;
        end
        PH_ACK_B: begin
          // both lines released, first acknowledge sample on this beat
          ent       = 1'b1;
          ent_ph    = PH_POLL;
          poll_chk  = 1'b1;
          poll_base = '0;
        end
        PH_RX_LOW: begin
          ent    = 1'b1;
          ent_ph = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          sh_nxt = {sh_r[6:0], item.sda_in};
          bc_nxt = bc_r + 1'b1;
          ent    = 1'b1;
          ent_ph = (bc_nxt >= BITS_PER_BYTE) ? PH_ANS_LOW : PH_RX_LOW;
        end
        PH_ANS_LOW: begin
          ent    = 1'b1;
          ent_ph = PH_ANS_HIGH;
        end
        PH_ANS_HIGH: begin
          fin         = 1'b1;
          fin_scl_low = 1'b1;
        end
        PH_STOP_A: begin
          ent    = 1'b1;
          ent_ph = PH_STOP_B;
        end
        PH_STOP_B: begin
          ent    = 1'b1;
          ent_ph = PH_STOP_C;
        end
        default: fin = 1'b1;
      endcase
    end

    if (ent) begin
      drv      = drive_for(ent_ph, sh_nxt[7], ackm_nxt);
      ph_nxt   = ent_ph;
      tick_nxt = drv.ticks;
      scl_nxt  = drv.scl;
      sda_nxt  = drv.sda;
    end

    if (poll_chk) begin
      poll_nxt = poll_base;
      if (!item.sda_in) begin
        fin         = 1'b1;
        fin_scl_low = 1'b1;
      end else if (poll_base >= poll_limit) begin
        // give up: one stop sequence, error flagged at its end
        op_nxt   = OP_STOP_ERR;
        drv      = drive_for(PH_STOP_A, sh_nxt[7], ackm_nxt);
        ph_nxt   = PH_STOP_A;
        tick_nxt = drv.ticks;
        scl_nxt  = drv.scl;
        sda_nxt  = drv.sda;
      end else begin
        poll_nxt = poll_base + 1'b1;
      end
    end

    if (fin) begin
      done     = 1'b1;
      err      = (op_r == OP_STOP_ERR);
      rd       = (op_r == OP_READ);
      op_nxt   = OP_IDLE;
      ph_nxt   = PH_IDLE;
      tick_nxt = '0;
      if (fin_scl_low) begin
        scl_nxt = 1'b0;
      end
    end

    res.scl       = scl_nxt;
    res.sda       = sda_nxt;
    res.busy      = (op_nxt != OP_IDLE);
    res.done      = done;
    res.nack      = err;
    res.read_data = (done && rd) ? sh_nxt : '0;
  end

endmodule
